[hdl/sfrp_pkg.sv]
// Package for the sync frame colour response parser.
// Holds the frame constants, register indexes and reset values; no dependencies.
`default_nettype none

package sfrp_pkg;

    localparam logic [7:0] SYNC_FIRST   = 8'hAF;
    localparam logic [7:0] SYNC_SECOND  = 8'hC1;
    localparam logic [7:0] HEADER_BYTES = 8'd2;
    localparam int unsigned KEEP_COUNT  = 3;

    localparam int unsigned ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_ACK_TYPE   = 1'b0,
        REG_RGB_LENGTH = 1'b1
    } reg_idx_t;

    localparam logic [7:0] ACK_TYPE_RESET   = 8'd1;
    localparam logic [7:0] RGB_LENGTH_RESET = 8'd5;

endpackage

`default_nettype wire

[hdl/sync_frame_rgb_response_parser.sv]
// Top level of the sync frame colour response parser: frame state machine,
// checksum, colour hold, result register and APB register port.
// Depends on sfrp_pkg.
`default_nettype none

// One received byte is taken per clock cycle (s_ready high), with no gaps
// between frames. The byte that completes a frame (last payload byte, or the
// second checksum byte when the length is 2) places one result in the output
// register, visible the cycle after. s_ready is low only while that register
// holds a result that m_ready does not take in the same cycle. The frame state,
// running sum and colour hold update in the same cycle the byte is accepted.
// Registers ack_type (0x0) and rgb_length (0x4) are written and read over APB.
module sync_frame_rgb_response_parser (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_rx_byte,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [7:0]                      m_blue,
    output logic [7:0]                      m_green,
    output logic [7:0]                      m_red,
    output logic                            m_checksum_ok,
    output logic                            m_colour_updated,
    output logic [7:0]                      m_frame_type,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfrp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    typedef enum logic [2:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_TYPE,
        ST_LEN,
        ST_CKHI,
        ST_CKLO,
        ST_PAYLOAD
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  ack_type_reg, rgb_length_reg;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  ckhi_reg, ckhi_next;
    logic [15:0] expected_reg, expected_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  first_reg [sfrp_pkg::KEEP_COUNT];
    logic [7:0]  first_next [sfrp_pkg::KEEP_COUNT];
    logic [7:0]  colour_reg [sfrp_pkg::KEEP_COUNT];
    logic [7:0]  colour_next [sfrp_pkg::KEEP_COUNT];

    logic        valid_reg;
    logic [7:0]  blue_reg, green_reg, red_reg, ftype_reg;
    logic        ok_reg, upd_reg;

    logic        accept, finish, sum_ok, update;
    logic        cfg_write;
    sfrp_pkg::reg_idx_t cfg_idx;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Frame state machine and checksum
    always_comb begin
        state_next    = state_reg;
        type_next     = type_reg;
        length_next   = length_reg;
        ckhi_next     = ckhi_reg;
        expected_next = expected_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        first_next    = first_reg;
        finish        = 1'b0;
        unique case (state_reg)
            ST_HUNT1: begin
                if (s_rx_byte == sfrp_pkg::SYNC_FIRST) state_next = ST_HUNT2;
            end
            ST_HUNT2: begin
                state_next = (s_rx_byte == sfrp_pkg::SYNC_SECOND) ? ST_TYPE : ST_HUNT1;
            end
            ST_TYPE: begin
                type_next  = s_rx_byte;
                state_next = ST_LEN;
            end
            ST_LEN: begin
                length_next = s_rx_byte;
                state_next  = ST_CKHI;
            end
            ST_CKHI: begin
                ckhi_next  = s_rx_byte;
                state_next = ST_CKLO;
            end
            ST_CKLO: begin
                expected_next = {ckhi_reg, s_rx_byte};
                sum_next      = '0;
                count_next    = '0;
                for (int i = 0; i < sfrp_pkg::KEEP_COUNT; i++) first_next[i] = '0;
                if (length_reg < sfrp_pkg::HEADER_BYTES) begin
                    state_next = ST_HUNT1;
                end else if (length_reg == sfrp_pkg::HEADER_BYTES) begin
                    finish     = 1'b1;
                    state_next = ST_HUNT1;
                end else begin
                    state_next = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                for (int i = 0; i < sfrp_pkg::KEEP_COUNT; i++) begin
                    if (count_reg == 8'(i)) first_next[i] = s_rx_byte;
                end
                sum_next   = sum_reg + {8'd0, s_rx_byte};
                count_next = count_reg + 8'd1;
                if (count_next >= length_reg - sfrp_pkg::HEADER_BYTES) begin
                    finish     = 1'b1;
                    state_next = ST_HUNT1;
                end
            end
            default: state_next = ST_HUNT1;
        endcase
    end

    assign sum_ok = (sum_next == expected_next);
    assign update = sum_ok && (type_reg == ack_type_reg) && (length_reg == rgb_length_reg);

    always_comb begin
        colour_next = colour_reg;
        if (finish && update) colour_next = first_next;
    end

    // Frame registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_HUNT1;
            type_reg     <= '0;
            length_reg   <= '0;
            ckhi_reg     <= '0;
            expected_reg <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            for (int i = 0; i < sfrp_pkg::KEEP_COUNT; i++) begin
                first_reg[i]  <= '0;
                colour_reg[i] <= '0;
            end
        end else if (accept) begin
            state_reg    <= state_next;
            type_reg     <= type_next;
            length_reg   <= length_next;
            ckhi_reg     <= ckhi_next;
            expected_reg <= expected_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            first_reg    <= first_next;
            colour_reg   <= colour_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept && finish) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && finish) begin
            blue_reg  <= colour_next[0];
            green_reg <= colour_next[1];
            red_reg   <= colour_next[2];
            ok_reg    <= sum_ok;
            upd_reg   <= update;
            ftype_reg <= type_reg;
        end
    end

    assign m_valid          = valid_reg;
    assign m_blue           = blue_reg;
    assign m_green          = green_reg;
    assign m_red            = red_reg;
    assign m_checksum_ok    = ok_reg;
    assign m_colour_updated = upd_reg;
    assign m_frame_type     = ftype_reg;

    // APB register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = sfrp_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_type_reg   <= sfrp_pkg::ACK_TYPE_RESET;
            rgb_length_reg <= sfrp_pkg::RGB_LENGTH_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                sfrp_pkg::REG_ACK_TYPE:   ack_type_reg   <= pwdata[7:0];
                sfrp_pkg::REG_RGB_LENGTH: rgb_length_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            sfrp_pkg::REG_ACK_TYPE:   prdata = {24'd0, ack_type_reg};
            sfrp_pkg::REG_RGB_LENGTH: prdata = {24'd0, rgb_length_reg};
            default:                  prdata = '0;
        endcase
    end

    // Checks
    a_upd_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_colour_updated || m_checksum_ok))
        else $error("colour update without checksum match");

    a_result_matches_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_blue == colour_reg[0] && m_green == colour_reg[1]
                     && m_red == colour_reg[2]))
        else $error("result colours differ from held colours");

    a_hunt_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && finish) |=> (state_reg == ST_HUNT1))
        else $error("frame end did not return to hunt");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire
